[sv/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

  // Queue geometry
  localparam int unsigned QDEPTH = 64;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = 7;

  // Field widths
  localparam int unsigned TICK_W = 32;
  localparam int unsigned SVC_W  = 16;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned OCC_W  = 40;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 184;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_LINE_LIMIT = 3'd0;
  localparam logic [CNT_W-1:0]  LINE_LIMIT_RST  = 7'd64;
  localparam logic [CNT_W-1:0]  QDEPTH_CNT      = CNT_W'(QDEPTH);

  // One queued customer
  typedef struct packed {
    logic [TICK_W-1:0] arrival_tick;
    logic [SVC_W-1:0]  service_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Per-request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

[sv/dtq_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module dtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/drop_tail_queue_service_tracker_unit.sv]
// Drop-tail single-server queue tracker.
// Each request on the slave stream is one simulation tick:
//   s_axis_tdata = {service_time[16:1], arrived[0]}, zero padded to 24 bits.
// Each tick produces exactly one result on the master stream carrying the
// per-tick events (service start, wait of the started entry, drop) and the
// running totals (line length, wait, arrivals, drops, occupancy sum).
// line_limit is written through the APB port at byte address 0; the user must
// write it only while idle, the block does not enforce this. A limit above the
// queue depth acts as the depth. Sequence: a tick passes through four states
// (accept, head read from the entry RAM, update, total/result load); a new
// request is taken only once the previous tick has left these states. The
// RAM's registered read and the wait accumulation after the wait subtraction
// set this sequence.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following tick holds in its final
// cycle until the output register frees up.
// Reset clears all counters, pointers and the sequencer; line_limit returns
// to 64. Entry RAM contents need no clearing: only pushed entries are read.
`default_nettype none

module drop_tail_queue_service_tracker_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // APB configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dtq_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  // Tick requests
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // arrived[0], service_time[16:1], zero pad [23:17]
  input  wire logic [dtq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Results
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // service_started[0], started_wait[32:1], arrival_dropped[33],
  // line_length[40:34], total_wait[72:41], total_arrivals[104:73],
  // total_drops[136:105], occupancy_sum[176:137], zero pad [183:177]
  output logic      [dtq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import dtq_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  line_limit_q;
  logic              arrived_q;
  logic [SVC_W-1:0]  svc_q;

  logic [TICK_W-1:0] tick_q, tick_d;
  logic [SVC_W-1:0]  sl_q, sl_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TOT_W-1:0]  wait_tot_q, wait_tot_d;
  logic [TOT_W-1:0]  arr_tot_q, arr_tot_d, drop_tot_q, drop_tot_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              started_q, started_d, dropped_q, dropped_d;
  logic [TOT_W-1:0]  waited_q, waited_d;

  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic              in_accept, out_load, ram_we;
  entry_t            ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LINE_LIMIT);
  assign prdata = (paddr == ADDR_LINE_LIMIT) ? {{(32-CNT_W){1'b0}}, line_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= LINE_LIMIT_RST;
    end else if (cfg_wr) begin
      line_limit_q <= pwdata[CNT_W-1:0];
    end
  end

  // Entry storage
  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata_raw)
  );
  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Handshakes
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_RD;
      ST_RD:   state_d = ST_EX;
      ST_EX:   state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  // Tick update: counters, pop of the head, push or drop
  logic [TICK_W-1:0] tick_inc;
  logic [SVC_W-1:0]  sl_dec;
  logic [OCC_W:0]    occ_sum;
  logic              pop, push;
  logic [CNT_W-1:0]  count_mid, limit_eff;

  always_comb begin
    tick_inc  = (tick_q == '1) ? tick_q : tick_q + 1'b1;
    sl_dec    = (sl_q != '0) ? sl_q - 1'b1 : sl_q;
    occ_sum   = {1'b0, occ_q} + (OCC_W+1)'(count_q);
    pop       = (sl_dec == '0) && (count_q != '0);
    count_mid = pop ? count_q - 1'b1 : count_q;
    limit_eff = (line_limit_q > QDEPTH_CNT) ? QDEPTH_CNT : line_limit_q;
    push      = arrived_q && (count_mid < limit_eff);

    ram_we                 = (state_q == ST_EX) && push;
    ram_wdata.arrival_tick = tick_inc;
    ram_wdata.service_time = svc_q;

    tick_d     = tick_q;
    sl_d       = sl_q;
    occ_d      = occ_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    arr_tot_d  = arr_tot_q;
    drop_tot_d = drop_tot_q;
    started_d  = started_q;
    dropped_d  = dropped_q;
    waited_d   = waited_q;

    if (state_q == ST_EX) begin
      tick_d    = tick_inc;
      occ_d     = occ_sum[OCC_W] ? {OCC_W{1'b1}} : occ_sum[OCC_W-1:0];
      sl_d      = pop ? ram_rdata.service_time : sl_dec;
      head_d    = pop ? ((head_q == PTR_W'(QDEPTH-1)) ? '0 : head_q + 1'b1) : head_q;
      tail_d    = push ? ((tail_q == PTR_W'(QDEPTH-1)) ? '0 : tail_q + 1'b1) : tail_q;
      count_d   = push ? count_mid + 1'b1 : count_mid;
      started_d = pop;
      waited_d  = pop ? tick_inc - ram_rdata.arrival_tick : '0;
      dropped_d = arrived_q && !push;
      if (arrived_q && (arr_tot_q != '1)) begin
        arr_tot_d = arr_tot_q + 1'b1;
      end
      if (arrived_q && !push && (drop_tot_q != '1)) begin
        drop_tot_d = drop_tot_q + 1'b1;
      end
    end
  end

  // Wait accumulation and result assembly
  logic [TOT_W:0] wait_sum;

  always_comb begin
    wait_sum   = {1'b0, wait_tot_q} + {1'b0, waited_q};
    wait_tot_d = out_load ? (wait_sum[TOT_W] ? {TOT_W{1'b1}} : wait_sum[TOT_W-1:0])
                          : wait_tot_q;
    out_data_d = {7'd0, occ_q, drop_tot_q, arr_tot_q, wait_tot_d, count_q,
                  dropped_q, waited_q, started_q};
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      sl_q        <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      wait_tot_q  <= '0;
      arr_tot_q   <= '0;
      drop_tot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tick_q     <= tick_d;
      sl_q       <= sl_d;
      occ_q      <= occ_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      wait_tot_q <= wait_tot_d;
      arr_tot_q  <= arr_tot_d;
      drop_tot_q <= drop_tot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      arrived_q <= s_axis_tdata[0];
      svc_q     <= s_axis_tdata[SVC_W:1];
    end
    started_q <= started_d;
    dropped_q <= dropped_d;
    waited_q  <= waited_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QDEPTH_CNT)
    else $error("queue occupancy beyond depth");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q - head_q) == count_q[PTR_W-1:0])
    else $error("head/tail pointers disagree with occupancy");

  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_RD))
    else $error("accepted request did not start a head read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
    else $error("pending result overwritten");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[40:34] <= QDEPTH_CNT))
    else $error("reported line length beyond depth");

endmodule

`default_nettype wire
